FILE: hdl/lsl_pkg.sv
package lsl_pkg;

	localparam int COUNT_W   = 16;
	localparam int LUX_W     = 12;
	localparam int RATIO_W   = 11;
	localparam int DIV_CELLS = RATIO_W;
	localparam int COEF_W    = 10;
	localparam int PROD_W    = COUNT_W + COEF_W;
	localparam int LUX_FRAC  = 14;
	localparam int SEGMENTS  = 8;

	localparam logic [PROD_W-1:0] LUX_HALF = PROD_W'(1) << (LUX_FRAC - 1);

	localparam logic [RATIO_W-1:0] SEG_LIMIT [SEGMENTS] = '{
		11'h040, 11'h080, 11'h0c0, 11'h100, 11'h138, 11'h19a, 11'h29a, 11'h29a
	};
	localparam logic [COEF_W-1:0] SEG_OFFSET [SEGMENTS] = '{
		10'h1f2, 10'h214, 10'h23f, 10'h270, 10'h16f, 10'h0d2, 10'h018, 10'h000
	};
	localparam logic [COEF_W-1:0] SEG_SLOPE [SEGMENTS] = '{
		10'h1be, 10'h2d1, 10'h37b, 10'h3fe, 10'h1fc, 10'h0fb, 10'h012, 10'h000
	};

	// one request moving down the divider row
	typedef struct packed {
		logic [COUNT_W-1:0] bb;
		logic [COUNT_W-1:0] ir;
		logic [COUNT_W-1:0] rem;
		logic [RATIO_W-1:0] sh;   // dividend bits still to come, quotient bits shifted in
		logic               ovf;  // ir >= 2*bb: ratio past last breakpoint (also bb == 0)
	} div_bus_t;

	typedef struct packed {
		logic [COEF_W-1:0] offset;
		logic [COEF_W-1:0] slope;
	} coef_t;

	function automatic coef_t seg_coef(input logic [RATIO_W-1:0] ratio);
		coef_t c;
		c.offset = '0;
		c.slope  = '0;
		for (int k = SEGMENTS - 1; k >= 0; k--) begin
			if (ratio <= SEG_LIMIT[k]) begin
				c.offset = SEG_OFFSET[k];
				c.slope  = SEG_SLOPE[k];
			end
		end
		return c;
	endfunction

endpackage

FILE: hdl/lsl_in_if.sv
interface lsl_in_if;
	import lsl_pkg::*;

	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] broadband_count;
	logic [COUNT_W-1:0] infrared_count;

	modport source (output valid, broadband_count, infrared_count, input ready);
	modport sink   (input valid, broadband_count, infrared_count, output ready);
endinterface

FILE: hdl/lsl_out_if.sv
interface lsl_out_if;
	import lsl_pkg::*;

	logic             valid;
	logic             ready;
	logic [LUX_W-1:0] lux_value;

	modport source (output valid, lux_value, input ready);
	modport sink   (input valid, lux_value, output ready);
endinterface

FILE: hdl/lsl_div_cell.sv
module lsl_div_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  lsl_pkg::div_bus_t in_bus,
	output logic              out_valid,
	input  logic              out_ready,
	output lsl_pkg::div_bus_t out_bus
);
	import lsl_pkg::*;

	logic               valid_q;
	div_bus_t           bus_q;
	logic [COUNT_W:0]   rem_ext;
	logic               ge;
	logic [COUNT_W:0]   rem_sub;
	div_bus_t           bus_n;

	// restoring step: one quotient bit
	always_comb begin
		rem_ext = {in_bus.rem, in_bus.sh[RATIO_W-1]};
		ge      = rem_ext >= {1'b0, in_bus.bb};
		rem_sub = ge ? rem_ext - {1'b0, in_bus.bb} : rem_ext;
		bus_n     = in_bus;
		bus_n.rem = rem_sub[COUNT_W-1:0];
		bus_n.sh  = {in_bus.sh[RATIO_W-2:0], ge};
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			bus_q <= bus_n;
		end
	end

	assign out_valid = valid_q;
	assign out_bus   = bus_q;
endmodule

FILE: hdl/lsl_lux_stage.sv
module lsl_lux_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  lsl_pkg::div_bus_t in_bus,
	lsl_out_if.source         lux
);
	import lsl_pkg::*;

	logic               valid_s1, valid_s2, valid_s3;
	logic               rdy1, rdy2, rdy3;
	logic [RATIO_W:0]   ratio_sum;
	coef_t              coef;
	coef_t              coef_s1;
	logic [COUNT_W-1:0] bb_s1, ir_s1;
	logic [PROD_W-1:0]  pos_s2, neg_s2;
	logic [PROD_W-1:0]  diff;
	logic [PROD_W-1:0]  acc;
	logic [LUX_W-1:0]   lux_s3;

	assign rdy3     = !valid_s3 || lux.ready;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign in_ready = rdy1;

	// round ratio from 2^10 to 2^9 scale, then pick the segment
	always_comb begin
		ratio_sum = {1'b0, in_bus.sh} + (RATIO_W+1)'(1);
		if (in_bus.ovf) begin
			coef = '0;
		end else begin
			coef = seg_coef(ratio_sum[RATIO_W:1]);
		end
	end

	always_comb begin
		diff = (pos_s2 > neg_s2) ? pos_s2 - neg_s2 : '0;
		acc  = diff + LUX_HALF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy1) begin
			coef_s1 <= coef;
			bb_s1   <= in_bus.bb;
			ir_s1   <= in_bus.ir;
		end
		if (valid_s1 && rdy2) begin
			pos_s2 <= PROD_W'(bb_s1) * PROD_W'(coef_s1.offset);
			neg_s2 <= PROD_W'(ir_s1) * PROD_W'(coef_s1.slope);
		end
		if (valid_s2 && rdy3) begin
			lux_s3 <= acc[LUX_FRAC +: LUX_W];
		end
	end

	assign lux.valid     = valid_s3;
	assign lux.lux_value = lux_s3;
endmodule

FILE: hdl/light_sensor_lux_calc.sv
// channel  dir  payload                                  role
// sample   in   broadband_count[16], infrared_count[16]  channel count pair
// lux      out  lux_value[12]                            illuminance, whole lux
//
// One request per cycle unless the output stalls; stages: 11 divider cells (one ratio bit
// each), segment select, two 16x10 multiplies, clamp/round into the output reg.
// Every stage holds its own valid; a stalled stage only blocks those behind it,
// so bubbles close up and requests enter while a result waits at the output.
// arst_n clears all valid bits; payload registers are not reset.
module light_sensor_lux_calc (
	input logic       clk,
	input logic       arst_n,
	lsl_in_if.sink    sample,
	lsl_out_if.source lux
);
	import lsl_pkg::*;

	logic     cell_valid [DIV_CELLS+1];
	logic     cell_ready [DIV_CELLS+1];
	div_bus_t cell_bus   [DIV_CELLS+1];

	// ratio beyond 2047 is past the last breakpoint; the quotient then fits 11 bits
	always_comb begin
		cell_bus[0].bb  = sample.broadband_count;
		cell_bus[0].ir  = sample.infrared_count;
		cell_bus[0].rem = {1'b0, sample.infrared_count[COUNT_W-1:1]};
		cell_bus[0].sh  = {sample.infrared_count[0], (RATIO_W-1)'(0)};
		cell_bus[0].ovf = {1'b0, sample.infrared_count} >= {sample.broadband_count, 1'b0};
	end

	assign cell_valid[0] = sample.valid;
	assign sample.ready  = cell_ready[0];

	for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
		lsl_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (cell_valid[i]),
			.in_ready  (cell_ready[i]),
			.in_bus    (cell_bus[i]),
			.out_valid (cell_valid[i+1]),
			.out_ready (cell_ready[i+1]),
			.out_bus   (cell_bus[i+1])
		);
	end

	lsl_lux_stage u_lux (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cell_valid[DIV_CELLS]),
		.in_ready (cell_ready[DIV_CELLS]),
		.in_bus   (cell_bus[DIV_CELLS]),
		.lux      (lux)
	);

	a_lux_range: assert property (@(posedge clk) disable iff (!arst_n)
		lux.valid |-> lux.lux_value <= LUX_W'(2496))
		else $error("lux result above largest possible value");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid[DIV_CELLS] && !cell_bus[DIV_CELLS].ovf
			|-> cell_bus[DIV_CELLS].rem < cell_bus[DIV_CELLS].bb)
		else $error("divider remainder not below divisor");

	a_first_cell: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid[1] && !cell_bus[1].ovf |-> cell_bus[1].bb != '0)
		else $error("zero broadband count not flagged");
endmodule
